@@ hw/rtl/button_gesture_detector_core_macros.svh @@
// Assertion macros shared by the button gesture detector RTL.
`ifndef BUTTON_GESTURE_DETECTOR_CORE_MACROS_SVH
`define BUTTON_GESTURE_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define BGD_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BGD_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BGD_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg)
`define BGD_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg)

`endif

`endif

@@ hw/rtl/bgd_pkg.sv @@
// Types, constants and helper functions for the button gesture detector.
package bgd_pkg;

  // Time base
  localparam int TIME_W = 32;
  localparam int STAMP_W = 32;
  localparam int MS_W = 16;
  localparam int THR_W = 26;
  localparam int CMP_W = (TIME_W > THR_W) ? TIME_W : THR_W;
  localparam int US_PER_MS = 1000;

  // Tallies
  localparam int TALLY_W = 8;
  localparam logic [TALLY_W-1:0] LONG_MARK = 8'hFF;
  localparam logic [TALLY_W-1:0] CLICK_MAX = 8'd254;

  // Request queue
  localparam int Q_DEPTH = 2;
  localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY   = 3'd4;

  // Register reset values in ms
  localparam logic [MS_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [MS_W-1:0] HOLD_TIME_RST  = 16'd1000;
  localparam logic [MS_W-1:0] REPEAT_RST     = 16'd0;
  localparam logic [MS_W-1:0] CLICK_RST      = 16'd300;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [THR_W-1:0]  thr_t;

  typedef enum logic [2:0] {
    EV_DOWN       = 3'd0,
    EV_UP         = 3'd1,
    EV_LONG_START = 3'd2,
    EV_LONG_HOLD  = 3'd3,
    EV_CLICK      = 3'd4
  } event_type_t;

  // One queued request: pressed level after polarity fix plus its stamp
  typedef struct packed {
    logic               pressed;
    logic [STAMP_W-1:0] stamp;
  } q_item_t;

  // Time thresholds in microseconds, front to back
  typedef struct packed {
    thr_t debounce;
    thr_t hold_time;
    thr_t repeat_period;
    thr_t click_timeout;
  } cfg_t;

  function automatic thr_t ms_scale_us(input logic [MS_W-1:0] ms);
    thr_t m;
    m = THR_W'(ms);
    return m * THR_W'(US_PER_MS);
  endfunction

  function automatic time_t to_time(input logic [STAMP_W-1:0] v);
    logic [TIME_W+STAMP_W-1:0] ext;
    ext = {{TIME_W{1'b0}}, v};
    return ext[TIME_W-1:0];
  endfunction

  // Elapsed time strictly greater than threshold
  function automatic logic time_over(input time_t d, input thr_t t);
    logic [CMP_W-1:0] dw;
    logic [CMP_W-1:0] tw;
    dw = CMP_W'(d);
    tw = CMP_W'(t);
    return dw > tw;
  endfunction

  // Elapsed time strictly less than threshold
  function automatic logic time_under(input time_t d, input thr_t t);
    logic [CMP_W-1:0] dw;
    logic [CMP_W-1:0] tw;
    dw = CMP_W'(d);
    tw = CMP_W'(t);
    return dw < tw;
  endfunction

endpackage

@@ hw/rtl/button_gesture_detector_core.sv @@
// Top level of the button gesture detector.
// Button gesture detector: takes one sample per request (raw pin level plus a
// microsecond timestamp) and returns at most one event per sample: down, up,
// long-press start, long-hold repeat with its number, or click with its count.
// Samples are accepted at one per clock while the two-entry queue has room;
// the queue separates the input side from the gesture state machine, whose
// per-sample update is combinational, so the sustained rate is one sample
// per cycle while the output is not stalled. A sample enters the queue on the
// edge that takes it, and its event is loaded into the output register when
// that is free. Thresholds are converted to microseconds when a register is
// written; write registers only while no sample is in flight. Register
// indexes: 0 debounce, 1 long press, 2 repeat period (0 turns repeats off),
// 3 click timeout (all in ms), 4 active low.
module button_gesture_detector_core import bgd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 raw_level,
  input  logic [STAMP_W-1:0]   now_us,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           event_type,
  output logic [TALLY_W-1:0]   event_count,
  output logic [STAMP_W-1:0]   event_time
);

  cfg_t    cfg;
  q_item_t push_item;
  q_item_t pop_item;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;

  // Input side
  bgd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .raw_level (raw_level),
    .now_us    (now_us),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .cfg       (cfg)
  );

  // Request queue
  bgd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // Gesture state machine and output
  bgd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_item      (pop_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_type  (event_type),
    .event_count (event_count),
    .event_time  (event_time)
  );

endmodule

@@ hw/rtl/bgd_front.sv @@
// Front end: configuration registers, input acceptance and polarity fix.
module bgd_front import bgd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 raw_level,
  input  logic [STAMP_W-1:0]   now_us,
  input  logic                 q_full,
  output logic                 push,
  output q_item_t              push_item,
  output cfg_t                 cfg
);

  logic pin_invert;

  // Configuration registers, thresholds kept in microseconds
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce      <= ms_scale_us(DEBOUNCE_RST);
      cfg.hold_time     <= ms_scale_us(HOLD_TIME_RST);
      cfg.repeat_period <= ms_scale_us(REPEAT_RST);
      cfg.click_timeout <= ms_scale_us(CLICK_RST);
      pin_invert        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  cfg.debounce      <= ms_scale_us(cfg_data);
        REG_HOLD_TIME: cfg.hold_time     <= ms_scale_us(cfg_data);
        REG_REPEAT:    cfg.repeat_period <= ms_scale_us(cfg_data);
        REG_CLICK:     cfg.click_timeout <= ms_scale_us(cfg_data);
        REG_POLARITY:  pin_invert        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Accept while the queue has room
  assign in_stall          = q_full;
  assign push              = in_valid && !q_full;
  assign push_item.pressed = raw_level ^ pin_invert;
  assign push_item.stamp   = now_us;

endmodule

@@ hw/rtl/bgd_queue.sv @@
// Short request queue between front and back.
`include "button_gesture_detector_core_macros.svh"
module bgd_queue import bgd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output q_item_t pop_item,
  output logic    empty
);

  q_item_t           slots [Q_DEPTH];
  logic [Q_AW-1:0]   wptr;
  logic [Q_AW-1:0]   rptr;
  logic [Q_CW-1:0]   count;

  function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
    return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count == Q_CW'(Q_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ptr_inc(wptr);
      end
      if (pop) begin
        rptr <= ptr_inc(rptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `BGD_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= Q_CW'(Q_DEPTH), "queue overfilled")
  `BGD_ASSERT_IMP(a_pop_nonempty, clk, rst, pop, count != '0, "pop from empty queue")

endmodule

@@ hw/rtl/bgd_back.sv @@
// Back end: debounce and gesture state update, output register.
`include "button_gesture_detector_core_macros.svh"
module bgd_back import bgd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                q_empty,
  input  q_item_t             q_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          event_type,
  output logic [TALLY_W-1:0]  event_count,
  output logic [STAMP_W-1:0]  event_time
);

  // Gesture state
  logic               raw_seen;
  logic               debounced_level;
  time_t              raw_change_time;
  time_t              phase_start_time;
  time_t              last_repeat_stamp;
  logic [TALLY_W-1:0] click_tally;
  logic [TALLY_W-1:0] repeat_tally;

  logic               debounced_level_next;
  time_t              raw_change_time_next;
  time_t              phase_start_time_next;
  time_t              last_repeat_stamp_next;
  logic [TALLY_W-1:0] click_tally_next;
  logic [TALLY_W-1:0] repeat_tally_next;

  logic               have;
  event_type_t        ev_type;
  logic [TALLY_W-1:0] ev_count;

  time_t now;
  logic  raw;
  logic  raw_changed;
  logic  deb_over;
  logic  long_over;
  logic  short_release;
  logic  click_over;
  logic  rep_over;
  logic  rep_on;
  logic  out_load;

  // Elapsed-time tests on the state as it stood before this request
  assign now           = to_time(q_item.stamp);
  assign raw           = q_item.pressed;
  assign raw_changed   = (raw != raw_seen);
  assign deb_over      = !raw_changed && time_over(now - raw_change_time, cfg.debounce);
  assign long_over     = time_over(now - phase_start_time, cfg.hold_time);
  assign short_release = time_under(now - phase_start_time, cfg.hold_time);
  assign click_over    = time_over(now - phase_start_time, cfg.click_timeout);
  assign rep_over      = time_over(now - last_repeat_stamp, cfg.repeat_period);
  assign rep_on        = (cfg.repeat_period != '0);

  assign out_load = !out_valid || !out_stall;
  assign pop      = !q_empty && out_load;

  // One step of the gesture machine; a stamp reset this step means zero elapsed
  always_comb begin
    logic phase_fresh;
    logic rep_fresh;
    phase_fresh            = 1'b0;
    rep_fresh              = 1'b0;
    have                   = 1'b0;
    ev_type                = EV_DOWN;
    ev_count               = '0;
    debounced_level_next   = debounced_level;
    raw_change_time_next   = raw_changed ? now : raw_change_time;
    phase_start_time_next  = phase_start_time;
    last_repeat_stamp_next = last_repeat_stamp;
    click_tally_next       = click_tally;
    repeat_tally_next      = repeat_tally;

    // Debounced edge
    if (deb_over && (debounced_level != raw)) begin
      debounced_level_next = raw;
      have                 = 1'b1;
      if (raw) begin
        ev_type                = EV_DOWN;
        phase_start_time_next  = now;
        last_repeat_stamp_next = now;
        phase_fresh            = 1'b1;
        rep_fresh              = 1'b1;
      end else begin
        ev_type = EV_UP;
        if (short_release) begin
          if (click_tally == LONG_MARK) begin
            click_tally_next = '0;
          end else if (click_tally < CLICK_MAX) begin
            click_tally_next = click_tally + 1'b1;
          end
          phase_start_time_next = now;
          phase_fresh           = 1'b1;
        end else begin
          click_tally_next = '0;
        end
      end
    end

    if (debounced_level_next) begin
      // Long press and repeats
      if (!phase_fresh && long_over) begin
        if (click_tally_next != LONG_MARK) begin
          click_tally_next       = LONG_MARK;
          repeat_tally_next      = '0;
          last_repeat_stamp_next = now;
          rep_fresh              = 1'b1;
          if (!have) begin
            have    = 1'b1;
            ev_type = EV_LONG_START;
          end
        end
        if (rep_on && !rep_fresh && rep_over) begin
          repeat_tally_next      = repeat_tally_next + 1'b1;
          last_repeat_stamp_next = now;
          if (!have) begin
            have     = 1'b1;
            ev_type  = EV_LONG_HOLD;
            ev_count = repeat_tally_next;
          end
        end
      end
    end else begin
      // Click report after release timeout
      if ((click_tally_next != '0) && (click_tally_next != LONG_MARK)) begin
        if (!phase_fresh && click_over) begin
          if (!have) begin
            have     = 1'b1;
            ev_type  = EV_CLICK;
            ev_count = click_tally_next;
          end
          click_tally_next = '0;
        end
      end else if (click_tally_next == LONG_MARK) begin
        click_tally_next = '0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_seen          <= 1'b0;
      debounced_level   <= 1'b0;
      raw_change_time   <= '0;
      phase_start_time  <= '0;
      last_repeat_stamp <= '0;
      click_tally       <= '0;
      repeat_tally      <= '0;
    end else if (pop) begin
      raw_seen          <= raw;
      debounced_level   <= debounced_level_next;
      raw_change_time   <= raw_change_time_next;
      phase_start_time  <= phase_start_time_next;
      last_repeat_stamp <= last_repeat_stamp_next;
      click_tally       <= click_tally_next;
      repeat_tally      <= repeat_tally_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= pop && have;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && have) begin
      event_type  <= ev_type;
      event_count <= ev_count;
      event_time  <= q_item.stamp;
    end
  end

  `BGD_ASSERT_NEXT(a_event_loads, clk, rst, pop && have, out_valid, "event not presented")
  `BGD_ASSERT_IMP(a_click_nonzero, clk, rst, out_valid && (event_type == EV_CLICK), event_count != '0, "click event with zero count")
  `BGD_ASSERT_IMP(a_edge_count_zero, clk, rst, out_valid && ((event_type == EV_DOWN) || (event_type == EV_UP) || (event_type == EV_LONG_START)), event_count == '0, "nonzero count on edge event")

endmodule

@@ verif/button_gesture_detector_core_tb.sv @@
// Self-checking testbench for button_gesture_detector_core: directed table, then random gestures.
module button_gesture_detector_core_tb;
  import bgd_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int HOLDOFF_AFTER = 500;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int STORM_PRESSES = 255;
  localparam int HOLD_SAMPLES = 30;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED = 3'd7;

  typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_op_t;
  // how a directed row is checked: by the predictor, or by a typed-in result
  typedef enum logic [1:0] { CHK_PREDICT, CHK_NONE, CHK_EVENT } row_check_t;
  typedef enum logic [1:0] { PAT_GESTURES, PAT_CLICK_STORM, PAT_HOLD_RUN } pattern_t;

  typedef struct packed {
    event_type_t        kind;
    logic [TALLY_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } gesture_event_t;

  typedef struct packed {
    row_op_t              op;
    row_check_t           chk;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 pin;
    logic [STAMP_W-1:0]   value;
    event_type_t          kind;
    logic [TALLY_W-1:0]   count;
  } table_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MS_W-1:0]      cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 raw_level;
  logic [STAMP_W-1:0]   now_us;
  logic                 out_valid;
  logic                 out_stall;
  logic [2:0]           event_type;
  logic [TALLY_W-1:0]   event_count;
  logic [STAMP_W-1:0]   event_time;

  // Predictor copy of the registers and gesture state
  logic [MS_W-1:0]    cfg_debounce_ms;
  logic [MS_W-1:0]    cfg_long_ms;
  logic [MS_W-1:0]    cfg_hold_ms;
  logic [MS_W-1:0]    cfg_click_ms;
  logic               cfg_invert;
  logic               seen_pressed;
  logic               level_pressed;
  logic [STAMP_W-1:0] change_stamp;
  logic [STAMP_W-1:0] press_stamp;
  logic [STAMP_W-1:0] hold_stamp;
  logic [TALLY_W-1:0] click_tally;
  logic [TALLY_W-1:0] hold_tally;

  gesture_event_t expected_events[$];
  table_row_t     directed_rows[$];

  // Typed-in result for the next directed sample
  bit                 typed_armed;
  bit                 typed_has;
  event_type_t        typed_kind;
  logic [TALLY_W-1:0] typed_count;

  int                 mismatch_count;
  int                 accepted_total;
  int                 phase_items;
  int                 burst_left;
  int                 cycle_count;
  bit                 holdoff_done;
  logic               pin_pressed;
  logic [STAMP_W-1:0] sample_time;

  button_gesture_detector_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .raw_level   (raw_level),
    .now_us      (now_us),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_type  (event_type),
    .event_count (event_count),
    .event_time  (event_time)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [STAMP_W-1:0] ms_us(input logic [MS_W-1:0] ms);
    return 32'(ms) * 32'd1000;
  endfunction

  // strictly more than the threshold, modulo the stamp width
  function automatic bit elapsed_past(input logic [STAMP_W-1:0] now_t,
                                      input logic [STAMP_W-1:0] since,
                                      input logic [STAMP_W-1:0] limit_us);
    logic [STAMP_W-1:0] diff;
    diff = now_t - since;
    return diff > limit_us;
  endfunction

  // Gesture predictor: updates the state copy, returns one when an event arises
  function automatic bit predict_gesture(input logic pin, input logic [STAMP_W-1:0] stamp,
                                         output event_type_t kind,
                                         output logic [TALLY_W-1:0] count);
    logic               pressed;
    bit                 has;
    logic [STAMP_W-1:0] held;
    pressed = pin ^ cfg_invert;
    has = 1'b0;
    kind = EV_DOWN;
    count = '0;
    if (pressed != seen_pressed) begin
      change_stamp = stamp;
      seen_pressed = pressed;
    end
    // debounced edge
    if (elapsed_past(stamp, change_stamp, ms_us(cfg_debounce_ms)) &&
        level_pressed != pressed) begin
      level_pressed = pressed;
      has = 1'b1;
      if (pressed) begin
        press_stamp = stamp;
        hold_stamp = stamp;
        kind = EV_DOWN;
      end else begin
        kind = EV_UP;
        held = stamp - press_stamp;
        if (held < ms_us(cfg_long_ms)) begin
          // short press: count a click, or drop a stale long-press mark
          if (click_tally == LONG_MARK) click_tally = '0;
          else if (click_tally < CLICK_MAX) click_tally = click_tally + 8'd1;
          press_stamp = stamp;
        end else begin
          click_tally = '0;
        end
      end
    end
    if (level_pressed) begin
      if (elapsed_past(stamp, press_stamp, ms_us(cfg_long_ms))) begin
        if (click_tally != LONG_MARK) begin
          click_tally = LONG_MARK;
          hold_tally = '0;
          hold_stamp = stamp;
          if (!has) begin
            has = 1'b1;
            kind = EV_LONG_START;
          end
        end
        if (cfg_hold_ms != '0 && elapsed_past(stamp, hold_stamp, ms_us(cfg_hold_ms))) begin
          hold_tally = hold_tally + 8'd1;
          hold_stamp = stamp;
          if (!has) begin
            has = 1'b1;
            kind = EV_LONG_HOLD;
            count = hold_tally;
          end
        end
      end
    end else if (click_tally != '0 && click_tally != LONG_MARK) begin
      // released long enough: report the clicks
      if (elapsed_past(stamp, press_stamp, ms_us(cfg_click_ms))) begin
        if (!has) begin
          has = 1'b1;
          kind = EV_CLICK;
          count = click_tally;
        end
        click_tally = '0;
      end
    end else if (click_tally == LONG_MARK) begin
      click_tally = '0;
    end
    return has;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 100)
      $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Mostly back to back, some short gaps, a few long ones, and gap-free bursts
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Time step scaled to one of the current thresholds, often right at it
  function automatic logic [STAMP_W-1:0] pick_delta();
    logic [STAMP_W-1:0] span;
    int                 r;
    case ($urandom_range(0, 3))
      0:       span = ms_us(cfg_debounce_ms);
      1:       span = ms_us(cfg_long_ms);
      2:       span = ms_us(cfg_hold_ms);
      default: span = ms_us(cfg_click_ms);
    endcase
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 25) return $urandom_range(1, 300);
    if (r < 45) return (span == '0) ? $urandom_range(0, 1) : span + $urandom_range(0, 2) - 1;
    if (r < 97) return $urandom_range(1, span + 1);
    return $urandom();
  endfunction

  // One sample request; prediction is taken at the accepting edge
  task automatic send_sample(input logic pin, input logic [STAMP_W-1:0] stamp);
    int                 gap;
    bit                 has;
    event_type_t        kind;
    logic [TALLY_W-1:0] count;
    gesture_event_t     ev;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_level <= pin;
    now_us <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accepted_total++;
    phase_items++;
    sample_time = stamp;
    has = predict_gesture(pin, stamp, kind, count);
    if (typed_armed) begin
      has = typed_has;
      kind = typed_kind;
      count = typed_count;
      typed_armed = 1'b0;
    end
    if (has) begin
      ev.kind = kind;
      ev.count = count;
      ev.stamp = stamp;
      expected_events.push_back(ev);
    end
  endtask

  // logical button level, advanced by delta
  task automatic send_level(input logic pressed, input logic [STAMP_W-1:0] delta);
    send_sample(pressed ^ cfg_invert, sample_time + delta);
  endtask

  // Wait for all events out, then let samples that give none drain
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE:  cfg_debounce_ms = data;
      REG_HOLD_TIME: cfg_long_ms = data;
      REG_REPEAT:    cfg_hold_ms = data;
      REG_CLICK:     cfg_click_ms = data;
      REG_POLARITY:  cfg_invert = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic add_sample(input logic pin, input logic [STAMP_W-1:0] stamp,
                            input row_check_t chk, input event_type_t kind,
                            input logic [TALLY_W-1:0] count);
    table_row_t row;
    row.op = ROW_SAMPLE;
    row.chk = chk;
    row.reg_idx = REG_DEBOUNCE;
    row.pin = pin;
    row.value = stamp;
    row.kind = kind;
    row.count = count;
    directed_rows.push_back(row);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] data);
    table_row_t row;
    row.op = ROW_WRITE;
    row.chk = CHK_PREDICT;
    row.reg_idx = idx;
    row.pin = 1'b0;
    row.value = 32'(data);
    row.kind = EV_DOWN;
    row.count = '0;
    directed_rows.push_back(row);
  endtask

  // Well-formed press or release with bounce, or plain noise
  task automatic play_gesture();
    int   r;
    int   n;
    logic lvl;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      pin_pressed = !pin_pressed;
      lvl = pin_pressed;
      n = $urandom_range(0, 3);
      repeat (n) begin
        send_level(lvl, $urandom_range(0, ms_us(cfg_debounce_ms)));
        lvl = !lvl;
      end
      n = $urandom_range(1, 5);
      repeat (n) send_level(pin_pressed, pick_delta());
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_level(1'($urandom_range(0, 1)), pick_delta());
    end
  endtask

  task automatic run_phase(input logic [MS_W-1:0] db, input logic [MS_W-1:0] lp,
                           input logic [MS_W-1:0] hp, input logic [MS_W-1:0] ct,
                           input logic al, input pattern_t pat, input int goal);
    settle_block();
    write_reg(REG_DEBOUNCE, db);
    write_reg(REG_HOLD_TIME, lp);
    write_reg(REG_REPEAT, hp);
    write_reg(REG_CLICK, ct);
    write_reg(REG_POLARITY, MS_W'(al));
    write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
              MS_W'($urandom()));
    phase_items = 0;
    case (pat)
      PAT_CLICK_STORM: begin
        // fast clicks up to and past the saturation point, then the timeout
        repeat (STORM_PRESSES) begin
          send_level(1'b1, $urandom_range(1, 40));
          send_level(1'b1, $urandom_range(1, 40));
          send_level(1'b0, $urandom_range(1, 40));
          send_level(1'b0, $urandom_range(1, 40));
        end
        send_level(1'b0, ms_us(ct) + $urandom_range(1, 5));
        pin_pressed = 1'b0;
      end
      PAT_HOLD_RUN: begin
        // one long hold with a run of repeats
        send_level(1'b0, $urandom_range(1, 40));
        send_level(1'b0, $urandom_range(1, 40));
        send_level(1'b1, $urandom_range(1, 40));
        send_level(1'b1, $urandom_range(1, 40));
        repeat (HOLD_SAMPLES) send_level(1'b1, ms_us(hp) + $urandom_range(1, 200));
        send_level(1'b0, $urandom_range(1, 40));
        send_level(1'b0, $urandom_range(1, 40));
        pin_pressed = 1'b0;
      end
      default: begin
        while (phase_items < goal) play_gesture();
      end
    endcase
  endtask

  // Receiver stalls: one long hold-off, then random bursts and quiet stretches
  initial begin : stall_gen
    int r;
    int len;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!holdoff_done && accepted_total >= HOLDOFF_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          out_stall <= 1'b0;
          len = $urandom_range(10, 60);
        end else if (r < 20) begin
          out_stall <= 1'b1;
          len = $urandom_range(15, 50);
        end else if (r < 60) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 4);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  // Compare each accepted event with the oldest expectation
  always @(posedge clk) begin : event_check
    gesture_event_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        report_mismatch("event with none expected", 32'(event_type), 32'(event_time));
      end else begin
        want = expected_events.pop_front();
        if (event_type !== want.kind)
          report_mismatch("event_type", 32'(event_type), 32'(want.kind));
        if (event_count !== want.count)
          report_mismatch("event_count", 32'(event_count), 32'(want.count));
        if (event_time !== want.stamp)
          report_mismatch("event_time", event_time, want.stamp);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    table_row_t row;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    raw_level <= 1'b0;
    now_us <= '0;
    mismatch_count = 0;
    accepted_total = 0;
    phase_items = 0;
    burst_left = 0;
    holdoff_done = 1'b0;
    typed_armed = 1'b0;
    pin_pressed = 1'b0;
    sample_time = '0;
    cfg_debounce_ms = DEBOUNCE_RST;
    cfg_long_ms = HOLD_TIME_RST;
    cfg_hold_ms = REPEAT_RST;
    cfg_click_ms = CLICK_RST;
    cfg_invert = 1'b0;
    seen_pressed = 1'b0;
    level_pressed = 1'b0;
    change_stamp = '0;
    press_stamp = '0;
    hold_stamp = '0;
    click_tally = '0;
    hold_tally = '0;

    // Directed table on reset registers: debounce, click, long press, repeat,
    // short release after a long press, ignored write, active low and wrap
    add_sample(1'b0, 32'd0,       CHK_NONE,    EV_DOWN, 8'd0);
    add_sample(1'b1, 32'd100,     CHK_PREDICT, EV_DOWN, 8'd0);
    add_sample(1'b1, 32'd20100,   CHK_PREDICT, EV_DOWN, 8'd0);
    add_sample(1'b1, 32'd20101,   CHK_EVENT,   EV_DOWN, 8'd0);
    add_sample(1'b0, 32'd50000,   CHK_PREDICT, EV_DOWN, 8'd0);
    add_sample(1'b0, 32'd70001,   CHK_EVENT,   EV_UP, 8'd0);
    add_sample(1'b0, 32'd370001,  CHK_PREDICT, EV_DOWN, 8'd0);
    add_sample(1'b0, 32'd370002,  CHK_EVENT,   EV_CLICK, 8'd1);
    add_sample(1'b1, 32'd400000,  CHK_PREDICT, EV_DOWN, 8'd0);
    add_sample(1'b1, 32'd420001,  CHK_PREDICT, EV_DOWN, 8'd0);
    add_sample(1'b1, 32'd1420001, CHK_PREDICT, EV_DOWN, 8'd0);
    add_sample(1'b1, 32'd1420002, CHK_EVENT,   EV_LONG_START, 8'd0);
    add_write(REG_REPEAT, 16'd1);
    add_sample(1'b1, 32'd1421003, CHK_PREDICT, EV_DOWN, 8'd0);
    add_write(REG_HOLD_TIME, 16'hFFFF);
    add_sample(1'b0, 32'd1430000, CHK_PREDICT, EV_DOWN, 8'd0);
    add_sample(1'b0, 32'd1450001, CHK_PREDICT, EV_DOWN, 8'd0);
    add_write(REG_HOLD_TIME, HOLD_TIME_RST);
    add_write(REG_LAST_UNUSED, 16'hFFFF);
    add_write(REG_POLARITY, 16'd1);
    add_sample(1'b1, 32'hFFFF_FFF0, CHK_PREDICT, EV_DOWN, 8'd0);
    add_sample(1'b0, 32'hFFFF_FFFF, CHK_PREDICT, EV_DOWN, 8'd0);
    add_sample(1'b0, 32'h0000_4E20, CHK_PREDICT, EV_DOWN, 8'd0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.op == ROW_WRITE) begin
        settle_block();
        write_reg(row.reg_idx, row.value[MS_W-1:0]);
      end else begin
        typed_armed = (row.chk != CHK_PREDICT);
        typed_has = (row.chk == CHK_EVENT);
        typed_kind = row.kind;
        typed_count = row.count;
        send_sample(row.pin, row.value);
      end
    end

    // Random gestures over several register settings, extremes included, then a click storm and a hold run
    run_phase(16'd2, 16'd40, 16'd5, 16'd15, 1'b0, PAT_GESTURES, 40);
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, PAT_GESTURES, 30);
    repeat (3) begin
      run_phase(MS_W'($urandom_range(0, 30)), MS_W'($urandom_range(0, 200)),
                MS_W'($urandom_range(0, 40)), MS_W'($urandom_range(0, 100)),
                1'($urandom_range(0, 1)), PAT_GESTURES, 20);
    end
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, PAT_GESTURES, 30);
    run_phase(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1, PAT_CLICK_STORM, 0);
    run_phase(16'd0, 16'd0, 16'd1, 16'd0, 1'b0, PAT_HOLD_RUN, 0);

    settle_block();
    if (expected_events.size() != 0)
      report_mismatch("events never produced", 32'(expected_events.size()), 32'd0);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
